// ----- rtl/dpht_pkg.sv -----
// ----------------------------------------------------------------------------
// dpht_pkg: shared types and constants of the depth-preferred hash table
// Slot layout, table geometry and modulo unit sizing.
// ----------------------------------------------------------------------------
package dpht_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int DV_W        = IDX_W + 1;

	localparam int KEY_W       = 64;
	localparam int CFG_W       = 11;
	localparam int AGE_W       = 8;
	localparam int CNT_W       = 32;

	localparam int MOD_BITS    = 4;
	localparam int MOD_STEPS   = KEY_W / MOD_BITS;
	localparam int MOD_CNT_W   = $clog2(MOD_STEPS);

	localparam logic FUNC_PROBE = 1'b0;
	localparam logic FUNC_STORE = 1'b1;

	localparam logic REG_ENTRIES = 1'b0;
	localparam logic REG_AGE     = 1'b1;

	localparam logic [CFG_W-1:0] ENTRIES_RESET = 11'd1024;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [7:0]       depth;
		logic [15:0]      score;
		logic [1:0]       flag;
		logic [15:0]      move;
		logic [AGE_W-1:0] age;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

endpackage

// ----- rtl/dpht_ram.sv -----
// ----------------------------------------------------------------------------
// dpht_ram: generic single-port synchronous RAM
// One access per cycle; read data registered.
// ----------------------------------------------------------------------------
module dpht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ----- rtl/dpht_mod.sv -----
// ----------------------------------------------------------------------------
// dpht_mod: iterative 64-bit key modulo a narrow divisor
// Restoring remainder, several key bits per cycle, done pulse at the end.
// ----------------------------------------------------------------------------
module dpht_mod (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [dpht_pkg::KEY_W-1:0]   dividend,
	input  logic [dpht_pkg::DV_W-1:0]    divisor,
	output logic                         done,
	output logic [dpht_pkg::IDX_W-1:0]   rem
);

	logic [dpht_pkg::KEY_W-1:0]     key_q;
	logic [dpht_pkg::DV_W-1:0]      dv_q;
	logic [dpht_pkg::IDX_W-1:0]     rem_q;
	logic [dpht_pkg::IDX_W-1:0]     rem_nxt;
	logic [dpht_pkg::MOD_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;

	always_comb begin
		logic [dpht_pkg::DV_W-1:0] t;
		logic [dpht_pkg::IDX_W-1:0] r;
		r = rem_q;
		for (int i = 0; i < dpht_pkg::MOD_BITS; i++) begin
			t = {r, key_q[dpht_pkg::KEY_W-1-i]};
			if (t >= dv_q) begin
				t = t - dv_q;
			end
			r = t[dpht_pkg::IDX_W-1:0];
		end
		rem_nxt = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == dpht_pkg::MOD_CNT_W'(dpht_pkg::MOD_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= dividend;
			dv_q  <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			key_q <= key_q << dpht_pkg::MOD_BITS;
			rem_q <= rem_nxt;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// ----- rtl/depth_preferred_hash_table_unit.sv -----
// ----------------------------------------------------------------------------
// depth_preferred_hash_table_unit: direct-mapped search cache
// Probe or store per transaction; slot = key mod entries in use,
// depth-preferred replacement, wrapping write counter.
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+-------------------
//  in      | func key depth score bound_flag best_move | in_valid/in_ready
//  out     | hit hit_score hit_move stored write_count | out_valid/out_ready
//  cfg     | cfg_index cfg_data                        | cfg_we, no wait
//
//  An item passes from acceptance to result through the modulo unit (4 key bits
//  per cycle), a step to take the remainder, one RAM read, and the compare and
//  write-back. With zero entries in use the item goes straight to compare.
//  After reset the slot RAM is cleared, one slot per cycle, with in_ready
//  low; configuration writes are taken throughout.
//  A result waiting in the output register does not block the next
//  acceptance; it blocks only the compare and write-back of the next result.
// ----------------------------------------------------------------------------
module depth_preferred_hash_table_unit (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            func,
	input  logic [63:0]                     key,
	input  logic signed [7:0]               depth,
	input  logic signed [15:0]              score,
	input  logic [1:0]                      bound_flag,
	input  logic [15:0]                     best_move,

	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            hit,
	output logic signed [15:0]              hit_score,
	output logic [15:0]                     hit_move,
	output logic                            stored,
	output logic [31:0]                     write_count,

	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [dpht_pkg::CFG_W-1:0]      cfg_data
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_READ,
		S_CMP
	} state_t;

	state_t                        state_q;
	logic [dpht_pkg::IDX_W-1:0]    clr_q;
	logic [dpht_pkg::IDX_W-1:0]    idx_q;
	logic [dpht_pkg::CFG_W-1:0]    entries_q;
	logic [dpht_pkg::AGE_W-1:0]    age_q;
	logic [dpht_pkg::CNT_W-1:0]    wcnt_q;
	logic                          zero_q;

	logic                          out_valid_q;
	logic                          hit_q;
	logic [15:0]                   hit_score_q;
	logic [15:0]                   hit_move_q;
	logic                          stored_q;

	logic                          func_q;
	logic [dpht_pkg::KEY_W-1:0]    key_q;
	logic [7:0]                    depth_q;
	logic [15:0]                   score_q;
	logic [1:0]                    flag_q;
	logic [15:0]                   move_q;
	logic [dpht_pkg::AGE_W-1:0]    slot_age_q;

	logic                          accept;
	logic [dpht_pkg::DV_W-1:0]     divisor;
	logic                          mod_done;
	logic [dpht_pkg::IDX_W-1:0]    mod_rem;
	logic                          out_free;
	logic                          key_match;
	logic                          do_store;
	logic                          do_hit;

	logic                          ram_we;
	logic [dpht_pkg::IDX_W-1:0]    ram_addr;
	dpht_pkg::slot_t               ram_wdata;
	dpht_pkg::slot_t               ram_rdata;
	dpht_pkg::slot_t               new_slot;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign divisor = (32'(entries_q) > 32'(dpht_pkg::TABLE_DEPTH))
		? dpht_pkg::DV_W'(dpht_pkg::TABLE_DEPTH) : dpht_pkg::DV_W'(entries_q);

	dpht_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && (divisor != '0)),
		.dividend (key),
		.divisor  (divisor),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	assign key_match = (ram_rdata.key == key_q);
	assign do_store  = !zero_q && (func_q == dpht_pkg::FUNC_STORE) &&
		((ram_rdata.key == '0) || key_match ||
		 ($signed(depth_q) >= $signed(ram_rdata.depth)));
	assign do_hit    = !zero_q && (func_q == dpht_pkg::FUNC_PROBE) && key_match &&
		($signed(ram_rdata.depth) >= $signed(depth_q));

	always_comb begin
		new_slot.key   = key_q;
		new_slot.depth = depth_q;
		new_slot.score = score_q;
		new_slot.flag  = flag_q;
		new_slot.move  = move_q;
		new_slot.age   = slot_age_q;
	end

	assign ram_we    = (state_q == S_CLEAR) || ((state_q == S_CMP) && out_free && do_store);
	assign ram_addr  = (state_q == S_CLEAR) ? clr_q : idx_q;
	assign ram_wdata = (state_q == S_CLEAR) ? '0 : new_slot;

	dpht_ram #(
		.WIDTH (dpht_pkg::SLOT_W),
		.DEPTH (dpht_pkg::TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= dpht_pkg::ENTRIES_RESET;
			age_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dpht_pkg::REG_ENTRIES: entries_q <= cfg_data;
				dpht_pkg::REG_AGE:     age_q     <= cfg_data[dpht_pkg::AGE_W-1:0];
				default:               ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q     <= func;
			key_q      <= key;
			depth_q    <= depth;
			score_q    <= score;
			flag_q     <= bound_flag;
			move_q     <= best_move;
			slot_age_q <= age_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			idx_q       <= '0;
			zero_q      <= 1'b0;
			wcnt_q      <= '0;
			out_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			hit_score_q <= '0;
			hit_move_q  <= '0;
			stored_q    <= 1'b0;
		end else begin
			if ((state_q == S_CMP) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == dpht_pkg::IDX_W'(dpht_pkg::TABLE_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						zero_q  <= (divisor == '0);
						state_q <= (divisor == '0) ? S_CMP : S_MOD;
					end
				end
				S_MOD: begin
					if (mod_done) begin
						idx_q   <= mod_rem;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (out_free) begin
						hit_q       <= do_hit;
						hit_score_q <= do_hit ? ram_rdata.score : '0;
						hit_move_q  <= do_hit ? ram_rdata.move : '0;
						stored_q    <= do_store;
						if (do_store) begin
							wcnt_q <= wcnt_q + 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign hit_score   = hit_score_q;
	assign hit_move    = hit_move_q;
	assign stored      = stored_q;
	assign write_count = wcnt_q;

	a_hit_store_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && stored))
		else $error("hit and stored both set");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !hit) |-> (hit_score == '0 && hit_move == '0))
		else $error("miss carries non-zero payload");

	a_wcnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(wcnt_q != $past(wcnt_q)) |-> (wcnt_q == $past(wcnt_q) + 1'b1) && stored_q)
		else $error("write counter moved without a store");

	a_mod_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> (state_q == S_MOD))
		else $error("modulo result outside modulo state");

endmodule

// ----- sim/tb_depth_preferred_hash_table_unit.sv -----
// ----------------------------------------------------------------------------
// tb_depth_preferred_hash_table_unit: self-checking bench of the search cache
// A mirror of the slot table predicts every probe and store answer. It starts
// with a directed pass over empty slots, zero keys, depth ties and collisions.
// Random phases follow under several slot counts (zero, one, oversized and
// typical) with random idling on both channels, but for one steady phase.
// ----------------------------------------------------------------------------
module tb_depth_preferred_hash_table_unit;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam logic [63:0] KEY_A       = 64'h0123_4567_89AB_CDEF;
	localparam logic [63:0] KEY_A_ALIAS = KEY_A + 64'd1024;
	localparam logic [63:0] KEY_ONES    = '1;
	localparam logic [63:0] KEY_SLOT0   = 64'd1024;

	typedef struct {
		logic        hit;
		logic [15:0] hit_score;
		logic [15:0] hit_move;
		logic        stored;
		logic [31:0] write_count;
	} table_answer_t;

	class slot_table_mirror;
		dpht_pkg::slot_t                 slots[dpht_pkg::TABLE_DEPTH];
		logic [31:0]                     store_total;
		logic [dpht_pkg::CFG_W-1:0]      entries;
		logic [dpht_pkg::AGE_W-1:0]      age;
		table_answer_t                   awaited[$];
		int                              mismatches;

		function new();
			foreach (slots[i]) slots[i] = '0;
			store_total = '0;
			entries     = dpht_pkg::ENTRIES_RESET;
			age         = '0;
			mismatches  = 0;
		endfunction

		function void set_register(logic idx, logic [dpht_pkg::CFG_W-1:0] data);
			if (idx == dpht_pkg::REG_ENTRIES) begin
				entries = data;
			end else begin
				age = data[dpht_pkg::AGE_W-1:0];
			end
		endfunction

		function void take_request(logic op, logic [63:0] k, logic signed [7:0] d,
				logic [15:0] sc, logic [1:0] fl, logic [15:0] mv);
			table_answer_t a;
			int unsigned   divisor;
			int unsigned   slot;
			a = '{hit: 1'b0, hit_score: '0, hit_move: '0, stored: 1'b0, write_count: '0};
			divisor = (entries > dpht_pkg::TABLE_DEPTH) ? dpht_pkg::TABLE_DEPTH : entries;
			if (divisor != 0) begin
				slot = int'(k % 64'(divisor));
				if (op == dpht_pkg::FUNC_STORE) begin
					if (slots[slot].key == '0 || slots[slot].key == k ||
							d >= $signed(slots[slot].depth)) begin
						slots[slot] = '{key: k, depth: d, score: sc, flag: fl, move: mv,
							age: age};
						store_total = store_total + 32'd1;
						a.stored    = 1'b1;
					end
				end else if (slots[slot].key == k && $signed(slots[slot].depth) >= d) begin
					a.hit       = 1'b1;
					a.hit_score = slots[slot].score;
					a.hit_move  = slots[slot].move;
				end
			end
			a.write_count = store_total;
			awaited.push_back(a);
		endfunction

		function void check_answer(logic h, logic [15:0] hs, logic [15:0] hm, logic st,
				logic [31:0] wc);
			table_answer_t e;
			if (awaited.size() == 0) begin
				$error("result transaction with no request outstanding");
				mismatches++;
				return;
			end
			e = awaited.pop_front();
			if (h !== e.hit) begin
				$error("hit: expected %0d, got %0d", e.hit, h);
				mismatches++;
			end
			if (hs !== e.hit_score) begin
				$error("hit_score: expected %0d, got %0d", $signed(e.hit_score), $signed(hs));
				mismatches++;
			end
			if (hm !== e.hit_move) begin
				$error("hit_move: expected 0x%04h, got 0x%04h", e.hit_move, hm);
				mismatches++;
			end
			if (st !== e.stored) begin
				$error("stored: expected %0d, got %0d", e.stored, st);
				mismatches++;
			end
			if (wc !== e.write_count) begin
				$error("write_count: expected %0d, got %0d", e.write_count, wc);
				mismatches++;
			end
		endfunction
	endclass

	logic                       clk        = 1'b0;
	logic                       arst_n     = 1'b0;
	logic                       in_valid   = 1'b0;
	logic                       func       = dpht_pkg::FUNC_PROBE;
	logic [63:0]                key        = '0;
	logic signed [7:0]          depth      = '0;
	logic signed [15:0]         score      = '0;
	logic [1:0]                 bound_flag = '0;
	logic [15:0]                best_move  = '0;
	logic                       out_ready  = 1'b0;
	logic                       cfg_we     = 1'b0;
	logic                       cfg_index  = dpht_pkg::REG_ENTRIES;
	logic [dpht_pkg::CFG_W-1:0] cfg_data   = '0;

	logic              in_ready;
	logic              out_valid;
	logic              hit;
	logic signed [15:0] hit_score;
	logic [15:0]       hit_move;
	logic              stored;
	logic [31:0]       write_count;

	slot_table_mirror  mirror;
	bit                steady = 1'b0;
	int unsigned       cycles = 0;

	depth_preferred_hash_table_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.key         (key),
		.depth       (depth),
		.score       (score),
		.bound_flag  (bound_flag),
		.best_move   (best_move),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.hit         (hit),
		.hit_score   (hit_score),
		.hit_move    (hit_move),
		.stored      (stored),
		.write_count (write_count),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				mirror.check_answer(hit, hit_score, hit_move, stored, write_count);
			end
			out_ready <= steady || ($urandom_range(99) >= 21);
		end
	end

	task automatic push_request(logic op, logic [63:0] k, logic signed [7:0] d,
			logic [15:0] sc, logic [1:0] fl, logic [15:0] mv);
		if (!steady && $urandom_range(99) < 21) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 21);
		end
		in_valid   <= 1'b1;
		func       <= op;
		key        <= k;
		depth      <= d;
		score      <= sc;
		bound_flag <= fl;
		best_move  <= mv;
		do @(posedge clk); while (!in_ready);
		mirror.take_request(op, k, d, sc, fl, mv);
	endtask

	task automatic finish_requests();
		in_valid <= 1'b0;
		while (mirror.awaited.size() != 0) @(posedge clk);
	endtask

	task automatic program_table(logic [dpht_pkg::CFG_W-1:0] entries_val,
			logic [dpht_pkg::AGE_W-1:0] age_val);
		cfg_we    <= 1'b1;
		cfg_index <= dpht_pkg::REG_ENTRIES;
		cfg_data  <= entries_val;
		@(posedge clk);
		mirror.set_register(dpht_pkg::REG_ENTRIES, entries_val);
		cfg_index <= dpht_pkg::REG_AGE;
		cfg_data  <= dpht_pkg::CFG_W'(age_val);
		@(posedge clk);
		mirror.set_register(dpht_pkg::REG_AGE, dpht_pkg::CFG_W'(age_val));
		cfg_we <= 1'b0;
	endtask

	task automatic run_random(int count, int unsigned entries_now);
		logic [63:0]       pool[16];
		logic [63:0]       base;
		logic [63:0]       k;
		logic              op;
		logic signed [7:0] d;
		int unsigned       stride;
		stride = (entries_now == 0) ? 1 :
			(entries_now > dpht_pkg::TABLE_DEPTH) ? dpht_pkg::TABLE_DEPTH : entries_now;
		base   = {$urandom, $urandom};
		for (int i = 0; i < 15; i++) begin
			case ($urandom_range(3))
				0: pool[i] = {$urandom, $urandom};
				1: pool[i] = 64'($urandom_range(4095));
				2: pool[i] = base + 64'(i * stride);
				default: pool[i] = {32'hFFFF_FFFF, $urandom};
			endcase
		end
		pool[15] = '0;
		repeat (count) begin
			if ($urandom_range(99) < 12) begin
				k  = {$urandom, $urandom};
				op = $urandom_range(1) ? dpht_pkg::FUNC_STORE : dpht_pkg::FUNC_PROBE;
			end else begin
				k  = pool[$urandom_range(15)];
				op = ($urandom_range(99) < 55) ? dpht_pkg::FUNC_STORE : dpht_pkg::FUNC_PROBE;
			end
			if ($urandom_range(3) == 0) begin
				d = 8'($urandom);
			end else begin
				d = 8'($urandom_range(12)) - 8'sd4;
			end
			push_request(op, k, d, 16'($urandom), 2'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		int unsigned phase_entries[10];
		int unsigned entries_now;
		mirror = new();
		phase_entries = '{0, 1, 2047, 1025, 7, 1023, 2, 64, 1024, 0};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		program_table(dpht_pkg::ENTRIES_RESET, '0);

		push_request(dpht_pkg::FUNC_PROBE, '0, 8'sd0, '0, '0, '0);
		push_request(dpht_pkg::FUNC_PROBE, '0, 8'sd1, '0, '0, '0);
		push_request(dpht_pkg::FUNC_PROBE, '0, 8'sh80, '0, '0, '0);
		push_request(dpht_pkg::FUNC_STORE, KEY_A, 8'sd5, 16'h8000, 2'd3, 16'hFFFF);
		push_request(dpht_pkg::FUNC_PROBE, KEY_A, 8'sd5, '0, '0, '0);
		push_request(dpht_pkg::FUNC_PROBE, KEY_A, 8'sd6, '0, '0, '0);
		push_request(dpht_pkg::FUNC_STORE, KEY_A_ALIAS, 8'sd4, 16'h1111, 2'd2, 16'h2222);
		push_request(dpht_pkg::FUNC_PROBE, KEY_A_ALIAS, 8'sh80, '0, '0, '0);
		push_request(dpht_pkg::FUNC_STORE, KEY_A_ALIAS, 8'sd5, 16'h3333, 2'd1, 16'h4444);
		push_request(dpht_pkg::FUNC_PROBE, KEY_A, 8'sh80, '0, '0, '0);
		push_request(dpht_pkg::FUNC_STORE, KEY_A, 8'sh80, 16'h5555, 2'd0, 16'h6666);
		push_request(dpht_pkg::FUNC_STORE, KEY_A_ALIAS, 8'sh80, 16'h7777, 2'd3, 16'h8888);
		push_request(dpht_pkg::FUNC_PROBE, KEY_A_ALIAS, 8'sh80, '0, '0, '0);
		push_request(dpht_pkg::FUNC_STORE, KEY_ONES, 8'sd127, 16'h7FFF, 2'd0, 16'h0000);
		push_request(dpht_pkg::FUNC_PROBE, KEY_ONES, 8'sd127, 16'hFFFF, 2'd3, 16'hFFFF);
		push_request(dpht_pkg::FUNC_PROBE, KEY_ONES, 8'sh80, '0, '0, '0);
		push_request(dpht_pkg::FUNC_STORE, '0, 8'sh80, 16'd1234, 2'd1, 16'h5555);
		push_request(dpht_pkg::FUNC_PROBE, '0, 8'sh80, '0, '0, '0);
		push_request(dpht_pkg::FUNC_PROBE, '0, 8'sd0, '0, '0, '0);
		push_request(dpht_pkg::FUNC_STORE, KEY_SLOT0, 8'sh80, 16'hAAAA, 2'd2, 16'hAAAA);
		push_request(dpht_pkg::FUNC_PROBE, KEY_SLOT0, 8'sh80, '0, '0, '0);
		push_request(dpht_pkg::FUNC_STORE, '0, 8'sd0, 16'h0F0F, 2'd3, 16'hF0F0);
		push_request(dpht_pkg::FUNC_PROBE, '0, 8'sd0, '0, '0, '0);
		finish_requests();

		for (int p = 0; p < 10; p++) begin
			entries_now = (p == 9) ? $urandom_range(2047, 1) : phase_entries[p];
			steady = (p == 5);
			program_table(dpht_pkg::CFG_W'(entries_now),
				(p == 1) ? 8'd255 : (p == 3) ? 8'd0 : 8'($urandom_range(255)));
			run_random((entries_now == 0) ? 40 : 150, entries_now);
			finish_requests();
		end
		steady = 1'b0;

		repeat (40) @(posedge clk);
		if (mirror.mismatches == 0 && mirror.awaited.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/dpht_pkg.sv
rtl/dpht_ram.sv
rtl/dpht_mod.sv
rtl/depth_preferred_hash_table_unit.sv
sim/tb_depth_preferred_hash_table_unit.sv
